// File: rtl/core/rlbs_pkg.sv
// ----------------------------------------------------------------------------
// rlbs_pkg
// Shared sizes, codes and port bundles of the run length blob store.
// ----------------------------------------------------------------------------
package rlbs_pkg;

   localparam int MAX_ROWS         = 64;
   localparam int MAX_RUNS_PER_ROW = 16;
   localparam int COORD_BITS       = 12;

   localparam int ROW_BITS    = $clog2(MAX_ROWS);
   localparam int SLOT_BITS   = $clog2(MAX_RUNS_PER_ROW);
   localparam int FILL_BITS   = SLOT_BITS + 1;
   localparam int ADDR_BITS   = ROW_BITS + SLOT_BITS;
   localparam int STORE_DEPTH = MAX_ROWS * MAX_RUNS_PER_ROW;
   localparam int RUN_BITS    = 2 * COORD_BITS;

   localparam int OP_BITS        = 2;
   localparam int READ_ROW_BITS  = 6;
   localparam int READ_SLOT_BITS = 4;
   localparam int STATUS_BITS    = 3;
   localparam int RUN_TOT_BITS   = 11;
   localparam int PIXEL_BITS     = 23;

   localparam logic [OP_BITS-1:0] OP_ADD   = 2'd0;
   localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd1;
   localparam logic [OP_BITS-1:0] OP_READ  = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_OK          = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_NOT_ADJ     = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_ROW_FULL    = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_HEIGHT_FULL = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_BAD_RUN     = 3'd4;
   localparam logic [STATUS_BITS-1:0] ST_BAD_READ    = 3'd5;

   typedef struct packed {
      logic [ROW_BITS-1:0]  rd_addr;
      logic                 wr_en;
      logic [ROW_BITS-1:0]  wr_addr;
      logic [FILL_BITS-1:0] wr_data;
      logic                 clr;
   } fill_req_type;

   typedef struct packed {
      logic                 rd_en;
      logic [ADDR_BITS-1:0] rd_addr;
      logic                 wr_en;
      logic [ADDR_BITS-1:0] wr_addr;
      logic [RUN_BITS-1:0]  wr_data;
   } run_req_type;

endpackage

// File: rtl/core/rlbs_fill_mem.sv
// ----------------------------------------------------------------------------
// rlbs_fill_mem
// Run count per row slot, with valid bits so that reset and clear empty
// every slot at once.
// ----------------------------------------------------------------------------
module rlbs_fill_mem (
   input  logic                            clock,
   input  logic                            reset,
   input  rlbs_pkg::fill_req_type          fill_req,
   output logic [rlbs_pkg::FILL_BITS-1:0]  rd_fill
);

   logic [rlbs_pkg::FILL_BITS-1:0] fill_mem [rlbs_pkg::MAX_ROWS];
   logic [rlbs_pkg::MAX_ROWS-1:0]  valid_ff;
   logic [rlbs_pkg::FILL_BITS-1:0] rd_data_ff;
   logic                           rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (fill_req.clr) begin
         valid_ff <= '0;
      end else if (fill_req.wr_en) begin
         valid_ff[fill_req.wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (fill_req.wr_en) begin
         fill_mem[fill_req.wr_addr] <= fill_req.wr_data;
      end
      rd_data_ff <= fill_mem[fill_req.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[fill_req.rd_addr];
      end
   end

   assign rd_fill = rd_valid_ff ? rd_data_ff : '0;

endmodule

// File: rtl/core/rlbs_run_mem.sv
// ----------------------------------------------------------------------------
// rlbs_run_mem
// Run store: left and right column of every run, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module rlbs_run_mem (
   input  logic                           clock,
   input  rlbs_pkg::run_req_type          run_req,
   output logic [rlbs_pkg::RUN_BITS-1:0]  rd_run
);

   logic [rlbs_pkg::RUN_BITS-1:0] run_mem [rlbs_pkg::STORE_DEPTH];
   logic [rlbs_pkg::RUN_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (run_req.wr_en) begin
         run_mem[run_req.wr_addr] <= run_req.wr_data;
      end
      if (run_req.rd_en) begin
         rd_data_ff <= run_mem[run_req.rd_addr];
      end
   end

   assign rd_run = rd_data_ff;

endmodule

// File: rtl/core/run_length_blob_store.sv
// ----------------------------------------------------------------------------
// run_length_blob_store
// Holds one blob as ordered horizontal runs per row in a circular row store.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item (add run, clear blob or read stored run); it is
//   taken on a clock edge with req_valid high and req_stall low. Every item
//   gives exactly one item on rsp_*, held in an output register until taken
//   (rsp_valid high, rsp_stall low).
//   After decode, an add or a read fetches the row's run count; a read then
//   fetches the run, while an accepted add walks the row with one compare
//   per cycle to find the insertion point, then moves the later runs up one
//   place per cycle through the run store's read and write ports and
//   writes the new run; the next item is taken on the cycle after the
//   result is loaded.
//   req_stall is high from acceptance until the result register is loaded.
//   A stalled receiver holds the result; a finished item waits for the
//   result register to free up, and the block takes no new item meanwhile.
//   Reset (synchronous) empties the blob; the run store itself
//   is not cleared.
// ----------------------------------------------------------------------------
module run_length_blob_store (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [rlbs_pkg::OP_BITS-1:0]           req_opcode,
   input  logic [rlbs_pkg::COORD_BITS-1:0]        req_x_left,
   input  logic [rlbs_pkg::COORD_BITS-1:0]        req_x_right,
   input  logic [rlbs_pkg::COORD_BITS-1:0]        req_row_y,
   input  logic [rlbs_pkg::READ_ROW_BITS-1:0]     req_read_row,
   input  logic [rlbs_pkg::READ_SLOT_BITS-1:0]    req_read_slot,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [rlbs_pkg::STATUS_BITS-1:0]       rsp_status,
   output logic [rlbs_pkg::RUN_TOT_BITS-1:0]      rsp_run_total,
   output logic [rlbs_pkg::PIXEL_BITS-1:0]        rsp_pixel_total,
   output logic [rlbs_pkg::COORD_BITS-1:0]        rsp_top_row,
   output logic [rlbs_pkg::COORD_BITS-1:0]        rsp_bottom_row,
   output logic                                   rsp_blob_empty,
   output logic [rlbs_pkg::COORD_BITS-1:0]        rsp_read_left,
   output logic [rlbs_pkg::COORD_BITS-1:0]        rsp_read_right,
   output logic [rlbs_pkg::COORD_BITS-1:0]        rsp_read_y
);

   localparam int CB = rlbs_pkg::COORD_BITS;
   localparam int RB = rlbs_pkg::ROW_BITS;
   localparam int SB = rlbs_pkg::SLOT_BITS;
   localparam int FB = rlbs_pkg::FILL_BITS;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DEC   = 3'd1;
   localparam logic [2:0] S_FILL  = 3'd2;
   localparam logic [2:0] S_SRCH  = 3'd3;
   localparam logic [2:0] S_SHIFT = 3'd4;
   localparam logic [2:0] S_WRITE = 3'd5;
   localparam logic [2:0] S_RDAT  = 3'd6;
   localparam logic [2:0] S_FIN   = 3'd7;

   localparam logic [1:0] K_INSIDE = 2'd0;
   localparam logic [1:0] K_ABOVE  = 2'd1;
   localparam logic [1:0] K_BELOW  = 2'd2;
   localparam logic [1:0] K_FIRST  = 2'd3;

   localparam logic [CB-1:0] COORD_MAX = {CB{1'b1}};

   logic [2:0]                               state_ff, state_in;
   logic [rlbs_pkg::OP_BITS-1:0]             op_ff, op_in;
   logic [CB-1:0]                            xl_ff, xl_in;
   logic [CB-1:0]                            xr_ff, xr_in;
   logic [CB-1:0]                            y_ff, y_in;
   logic [rlbs_pkg::READ_ROW_BITS-1:0]       rrow_ff, rrow_in;
   logic [rlbs_pkg::READ_SLOT_BITS-1:0]      rslot_ff, rslot_in;
   logic [RB-1:0]                            slot_ff, slot_in;
   logic [1:0]                               kind_ff, kind_in;
   logic [FB-1:0]                            fill_n_ff, fill_n_in;
   logic [SB-1:0]                            pos_ff, pos_in;
   logic [SB-1:0]                            cur_ff, cur_in;
   logic [rlbs_pkg::STATUS_BITS-1:0]         status_ff, status_in;
   logic                                     rd_ok_ff, rd_ok_in;

   logic [RB-1:0]                            top_slot_ff, top_slot_in;
   logic [CB-1:0]                            top_ff, top_in;
   logic [CB-1:0]                            bot_ff, bot_in;
   logic                                     empty_ff, empty_in;
   logic [rlbs_pkg::RUN_TOT_BITS-1:0]        runs_ff, runs_in;
   logic [rlbs_pkg::PIXEL_BITS-1:0]          pix_ff, pix_in;

   logic                                     rsp_valid_ff, rsp_valid_in;
   logic [rlbs_pkg::STATUS_BITS-1:0]         rsp_status_ff, rsp_status_in;
   logic [rlbs_pkg::RUN_TOT_BITS-1:0]        rsp_runs_ff, rsp_runs_in;
   logic [rlbs_pkg::PIXEL_BITS-1:0]          rsp_pix_ff, rsp_pix_in;
   logic [CB-1:0]                            rsp_top_ff, rsp_top_in;
   logic [CB-1:0]                            rsp_bot_ff, rsp_bot_in;
   logic                                     rsp_empty_ff, rsp_empty_in;
   logic [CB-1:0]                            rsp_rl_ff, rsp_rl_in;
   logic [CB-1:0]                            rsp_rr_ff, rsp_rr_in;
   logic [CB-1:0]                            rsp_ry_ff, rsp_ry_in;

   rlbs_pkg::fill_req_type                   fill_req;
   rlbs_pkg::run_req_type                    run_req;
   logic [FB-1:0]                            rd_fill;
   logic [rlbs_pkg::RUN_BITS-1:0]            rd_run;

   logic [CB-1:0]                            diff;
   logic                                     h_full;
   logic [CB-1:0]                            run_right;

   rlbs_fill_mem u_fill (
      .clock    (clock),
      .reset    (reset),
      .fill_req (fill_req),
      .rd_fill  (rd_fill)
   );

   rlbs_run_mem u_run (
      .clock   (clock),
      .run_req (run_req),
      .rd_run  (rd_run)
   );

   assign diff      = bot_ff - top_ff;
   assign h_full    = 32'(diff) >= 32'(rlbs_pkg::MAX_ROWS - 1);
   assign run_right = rd_run[CB-1:0];

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      xl_in        = xl_ff;
      xr_in        = xr_ff;
      y_in         = y_ff;
      rrow_in      = rrow_ff;
      rslot_in     = rslot_ff;
      slot_in      = slot_ff;
      kind_in      = kind_ff;
      fill_n_in    = fill_n_ff;
      pos_in       = pos_ff;
      cur_in       = cur_ff;
      status_in    = status_ff;
      rd_ok_in     = rd_ok_ff;
      top_slot_in  = top_slot_ff;
      top_in       = top_ff;
      bot_in       = bot_ff;
      empty_in     = empty_ff;
      runs_in      = runs_ff;
      pix_in       = pix_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_runs_in   = rsp_runs_ff;
      rsp_pix_in    = rsp_pix_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_bot_in    = rsp_bot_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_rl_in     = rsp_rl_ff;
      rsp_rr_in     = rsp_rr_ff;
      rsp_ry_in     = rsp_ry_ff;

      fill_req         = '0;
      fill_req.rd_addr = slot_ff;
      run_req          = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_opcode;
               xl_in    = req_x_left;
               xr_in    = req_x_right;
               y_in     = req_row_y;
               rrow_in  = req_read_row;
               rslot_in = req_read_slot;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            rd_ok_in  = 1'b0;
            status_in = rlbs_pkg::ST_OK;
            state_in  = S_FIN;
            case (op_ff)
               rlbs_pkg::OP_ADD: begin
                  if (xl_ff > xr_ff) begin
                     status_in = rlbs_pkg::ST_BAD_RUN;
                  end else if (empty_ff) begin
                     slot_in  = '0;
                     kind_in  = K_FIRST;
                     state_in = S_FILL;
                  end else if (y_ff >= top_ff && y_ff <= bot_ff) begin
                     slot_in  = top_slot_ff + RB'(y_ff - top_ff);
                     kind_in  = K_INSIDE;
                     state_in = S_FILL;
                  end else if (top_ff != '0 && y_ff == top_ff - CB'(1)) begin
                     if (h_full) begin
                        status_in = rlbs_pkg::ST_HEIGHT_FULL;
                     end else begin
                        slot_in  = top_slot_ff - RB'(1);
                        kind_in  = K_ABOVE;
                        state_in = S_FILL;
                     end
                  end else if (bot_ff != COORD_MAX && y_ff == bot_ff + CB'(1)) begin
                     if (h_full) begin
                        status_in = rlbs_pkg::ST_HEIGHT_FULL;
                     end else begin
                        slot_in  = top_slot_ff + RB'(diff) + RB'(1);
                        kind_in  = K_BELOW;
                        state_in = S_FILL;
                     end
                  end else begin
                     status_in = rlbs_pkg::ST_NOT_ADJ;
                  end
               end
               rlbs_pkg::OP_CLEAR: begin
                  fill_req.clr = 1'b1;
                  top_slot_in  = '0;
                  top_in       = '0;
                  bot_in       = '0;
                  empty_in     = 1'b1;
                  runs_in      = '0;
                  pix_in       = '0;
               end
               rlbs_pkg::OP_READ: begin
                  if (empty_ff || 32'(rrow_ff) > 32'(diff)) begin
                     status_in = rlbs_pkg::ST_BAD_READ;
                  end else begin
                     slot_in  = top_slot_ff + RB'(rrow_ff);
                     state_in = S_FILL;
                  end
               end
               default: begin
                  status_in = rlbs_pkg::ST_OK;
               end
            endcase
            fill_req.rd_addr = slot_in;
         end
         S_FILL: begin
            fill_n_in = rd_fill;
            pos_in    = '0;
            if (op_ff == rlbs_pkg::OP_READ) begin
               if (32'(rslot_ff) < 32'(rd_fill)) begin
                  run_req.rd_en   = 1'b1;
                  run_req.rd_addr = {slot_ff, SB'(rslot_ff)};
                  state_in        = S_RDAT;
               end else begin
                  status_in = rlbs_pkg::ST_BAD_READ;
                  state_in  = S_FIN;
               end
            end else if (32'(rd_fill) >= 32'(rlbs_pkg::MAX_RUNS_PER_ROW)) begin
               status_in = rlbs_pkg::ST_ROW_FULL;
               state_in  = S_FIN;
            end else if (rd_fill == '0) begin
               state_in = S_WRITE;
            end else begin
               run_req.rd_en   = 1'b1;
               run_req.rd_addr = {slot_ff, SB'(0)};
               state_in        = S_SRCH;
            end
         end
         S_SRCH: begin
            if (xl_ff > run_right) begin
               pos_in = pos_ff + SB'(1);
               if (32'(pos_ff) + 32'd1 == 32'(fill_n_ff)) begin
                  state_in = S_WRITE;
               end else begin
                  run_req.rd_en   = 1'b1;
                  run_req.rd_addr = {slot_ff, pos_in};
               end
            end else begin
               cur_in          = SB'(fill_n_ff - FB'(1));
               run_req.rd_en   = 1'b1;
               run_req.rd_addr = {slot_ff, cur_in};
               state_in        = S_SHIFT;
            end
         end
         S_SHIFT: begin
            run_req.wr_en   = 1'b1;
            run_req.wr_addr = {slot_ff, cur_ff + SB'(1)};
            run_req.wr_data = rd_run;
            if (cur_ff == pos_ff) begin
               state_in = S_WRITE;
            end else begin
               cur_in          = cur_ff - SB'(1);
               run_req.rd_en   = 1'b1;
               run_req.rd_addr = {slot_ff, cur_in};
            end
         end
         S_WRITE: begin
            run_req.wr_en    = 1'b1;
            run_req.wr_addr  = {slot_ff, pos_ff};
            run_req.wr_data  = {xl_ff, xr_ff};
            fill_req.wr_en   = 1'b1;
            fill_req.wr_addr = slot_ff;
            fill_req.wr_data = fill_n_ff + FB'(1);
            case (kind_ff)
               K_FIRST: begin
                  top_slot_in = '0;
                  top_in      = y_ff;
                  bot_in      = y_ff;
                  empty_in    = 1'b0;
               end
               K_ABOVE: begin
                  top_slot_in = slot_ff;
                  top_in      = y_ff;
               end
               K_BELOW: begin
                  bot_in = y_ff;
               end
               default: begin
                  top_in = top_ff;
               end
            endcase
            runs_in   = runs_ff + rlbs_pkg::RUN_TOT_BITS'(1);
            pix_in    = pix_ff + rlbs_pkg::PIXEL_BITS'(xr_ff - xl_ff)
                        + rlbs_pkg::PIXEL_BITS'(1);
            status_in = rlbs_pkg::ST_OK;
            state_in  = S_FIN;
         end
         S_RDAT: begin
            rd_ok_in  = 1'b1;
            status_in = rlbs_pkg::ST_OK;
            state_in  = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_runs_in   = runs_ff;
               rsp_pix_in    = pix_ff;
               rsp_top_in    = top_ff;
               rsp_bot_in    = bot_ff;
               rsp_empty_in  = empty_ff;
               rsp_rl_in     = rd_ok_ff ? rd_run[2*CB-1:CB] : '0;
               rsp_rr_in     = rd_ok_ff ? rd_run[CB-1:0] : '0;
               rsp_ry_in     = rd_ok_ff ? top_ff + CB'(rrow_ff) : '0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         top_slot_ff  <= '0;
         top_ff       <= '0;
         bot_ff       <= '0;
         empty_ff     <= 1'b1;
         runs_ff      <= '0;
         pix_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rd_ok_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_slot_ff  <= top_slot_in;
         top_ff       <= top_in;
         bot_ff       <= bot_in;
         empty_ff     <= empty_in;
         runs_ff      <= runs_in;
         pix_ff       <= pix_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_ok_ff     <= rd_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      xl_ff         <= xl_in;
      xr_ff         <= xr_in;
      y_ff          <= y_in;
      rrow_ff       <= rrow_in;
      rslot_ff      <= rslot_in;
      slot_ff       <= slot_in;
      kind_ff       <= kind_in;
      fill_n_ff     <= fill_n_in;
      pos_ff        <= pos_in;
      cur_ff        <= cur_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_runs_ff   <= rsp_runs_in;
      rsp_pix_ff    <= rsp_pix_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_bot_ff    <= rsp_bot_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_rl_ff     <= rsp_rl_in;
      rsp_rr_ff     <= rsp_rr_in;
      rsp_ry_ff     <= rsp_ry_in;
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_run_total   = rsp_runs_ff;
   assign rsp_pixel_total = rsp_pix_ff;
   assign rsp_top_row     = rsp_top_ff;
   assign rsp_bottom_row  = rsp_bot_ff;
   assign rsp_blob_empty  = rsp_empty_ff;
   assign rsp_read_left   = rsp_rl_ff;
   assign rsp_read_right  = rsp_rr_ff;
   assign rsp_read_y      = rsp_ry_ff;

`ifndef SYNTHESIS
   // an empty blob holds no runs and no pixels
   a_empty_counts: assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> (runs_ff == '0 && pix_ff == '0))
      else $error("empty blob with nonzero counts");

   // blob height stays within the row store
   a_height: assert property (@(posedge clock) disable iff (reset)
      !empty_ff |-> (bot_ff >= top_ff && 32'(diff) < 32'(rlbs_pkg::MAX_ROWS)))
      else $error("blob height out of range");

   // search never looks beyond the runs held in the row
   a_srch_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SRCH) |-> (32'(pos_ff) < 32'(fill_n_ff)))
      else $error("search past row fill");

   // shift source never drops below the insertion point
   a_shift_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (cur_ff >= pos_ff))
      else $error("shift below insertion point");

   // a committed run always leaves a non-empty blob
   a_write_commit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE) |=> (state_ff == S_FIN && !empty_ff))
      else $error("run commit did not fill blob");
`endif

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Checks the run length blob store against a cycle-free predictor of its blob:
// directed items at the image edges, ordered insertion, full rows and full
// height, then random blob building sessions under changing idle patterns and
// one long receiver hold-off. Every result is compared field by field.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rlbs_pkg::*;

   localparam int COORD_MAX   = 2 ** COORD_BITS - 1;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

   typedef logic [COORD_BITS-1:0] coord_t;

   typedef enum int {GROW_TALL, PACK_DENSE, MIXED_SHAPE} shape_style_e;

   typedef struct packed {
      logic [OP_BITS-1:0]        opcode;
      coord_t                    x_left;
      coord_t                    x_right;
      coord_t                    row_y;
      logic [READ_ROW_BITS-1:0]  read_row;
      logic [READ_SLOT_BITS-1:0] read_slot;
   } blob_req_t;

   typedef struct packed {
      logic [STATUS_BITS-1:0]  status;
      logic [RUN_TOT_BITS-1:0] run_total;
      logic [PIXEL_BITS-1:0]   pixel_total;
      coord_t                  top_row;
      coord_t                  bottom_row;
      logic                    blob_empty;
      coord_t                  read_left;
      coord_t                  read_right;
      coord_t                  read_y;
   } blob_result_t;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [OP_BITS-1:0] req_opcode;
   coord_t req_x_left;
   coord_t req_x_right;
   coord_t req_row_y;
   logic [READ_ROW_BITS-1:0] req_read_row;
   logic [READ_SLOT_BITS-1:0] req_read_slot;
   logic rsp_valid;
   logic rsp_stall;
   logic [STATUS_BITS-1:0] rsp_status;
   logic [RUN_TOT_BITS-1:0] rsp_run_total;
   logic [PIXEL_BITS-1:0] rsp_pixel_total;
   coord_t rsp_top_row;
   coord_t rsp_bottom_row;
   logic rsp_blob_empty;
   coord_t rsp_read_left;
   coord_t rsp_read_right;
   coord_t rsp_read_y;

   // predicted blob
   coord_t shape_left [STORE_DEPTH];
   coord_t shape_right [STORE_DEPTH];
   logic [FILL_BITS-1:0] row_count [MAX_ROWS];
   logic [ROW_BITS-1:0] head_slot;
   coord_t first_row;
   coord_t last_row;
   logic shape_empty;
   logic [RUN_TOT_BITS-1:0] runs_in_shape;
   logic [PIXEL_BITS-1:0] pixels_in_shape;

   blob_result_t results_due [$];

   int send_idle_pct;
   int recv_idle_pct;
   int hold_cycles;
   int cycle_count;
   int error_count;
   int items_sent;
   int results_checked;
   int status_tally [8];

   run_length_blob_store i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_x_left      (req_x_left),
      .req_x_right     (req_x_right),
      .req_row_y       (req_row_y),
      .req_read_row    (req_read_row),
      .req_read_slot   (req_read_slot),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_run_total   (rsp_run_total),
      .rsp_pixel_total (rsp_pixel_total),
      .rsp_top_row     (rsp_top_row),
      .rsp_bottom_row  (rsp_bottom_row),
      .rsp_blob_empty  (rsp_blob_empty),
      .rsp_read_left   (rsp_read_left),
      .rsp_read_right  (rsp_read_right),
      .rsp_read_y      (rsp_read_y)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due", cycle_count,
                  results_due.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic void clear_shape();
      foreach (row_count[r]) row_count[r] = '0;
      head_slot = '0;
      first_row = '0;
      last_row = '0;
      shape_empty = 1'b1;
      runs_in_shape = '0;
      pixels_in_shape = '0;
   endfunction

   function automatic void insert_ordered(input logic [ROW_BITS-1:0] slot, input coord_t xl,
                                          input coord_t xr);
      int base;
      int n;
      int pos;
      base = slot * MAX_RUNS_PER_ROW;
      n = row_count[slot];
      pos = 0;
      while (pos < n && xl > shape_right[base + pos]) pos++;
      for (int k = n; k > pos; k--) begin
         shape_left[base + k] = shape_left[base + k - 1];
         shape_right[base + k] = shape_right[base + k - 1];
      end
      shape_left[base + pos] = xl;
      shape_right[base + pos] = xr;
      row_count[slot] = n + 1;
   endfunction

   function automatic logic [STATUS_BITS-1:0] add_to_shape(input coord_t xl, input coord_t xr,
                                                          input coord_t y);
      int height;
      logic [ROW_BITS-1:0] slot;
      if (xl > xr) return ST_BAD_RUN;
      if (shape_empty) begin
         head_slot = '0;
         first_row = y;
         last_row = y;
         shape_empty = 1'b0;
         insert_ordered('0, xl, xr);
      end else begin
         height = int'(last_row) - int'(first_row) + 1;
         if (y >= first_row && y <= last_row) begin
            // row slots wrap round the circular store
            slot = head_slot + (y - first_row);
            if (row_count[slot] >= MAX_RUNS_PER_ROW) return ST_ROW_FULL;
            insert_ordered(slot, xl, xr);
         end else if (first_row != '0 && y == first_row - 1'b1) begin
            if (height >= MAX_ROWS) return ST_HEIGHT_FULL;
            head_slot = head_slot - 1'b1;
            first_row = y;
            insert_ordered(head_slot, xl, xr);
         end else if (last_row != '1 && y == last_row + 1'b1) begin
            if (height >= MAX_ROWS) return ST_HEIGHT_FULL;
            slot = head_slot + height[ROW_BITS-1:0];
            last_row = y;
            insert_ordered(slot, xl, xr);
         end else begin
            return ST_NOT_ADJ;
         end
      end
      runs_in_shape = runs_in_shape + 1'b1;
      pixels_in_shape = pixels_in_shape + (xr - xl + 1'b1);
      return ST_OK;
   endfunction

   function automatic blob_result_t next_blob_result(input blob_req_t item);
      blob_result_t res;
      int height;
      int idx;
      logic [ROW_BITS-1:0] slot;
      res = '0;
      case (item.opcode)
         OP_ADD: begin
            res.status = add_to_shape(item.x_left, item.x_right, item.row_y);
         end
         OP_CLEAR: begin
            clear_shape();
         end
         OP_READ: begin
            res.status = ST_BAD_READ;
            height = int'(last_row) - int'(first_row) + 1;
            if (!shape_empty && item.read_row < height) begin
               slot = head_slot + item.read_row;
               if (item.read_slot < row_count[slot]) begin
                  idx = slot * MAX_RUNS_PER_ROW + item.read_slot;
                  res.read_left = shape_left[idx];
                  res.read_right = shape_right[idx];
                  res.read_y = first_row + item.read_row;
                  res.status = ST_OK;
               end
            end
         end
         default: begin
         end
      endcase
      res.run_total = runs_in_shape;
      res.pixel_total = pixels_in_shape;
      res.top_row = first_row;
      res.bottom_row = last_row;
      res.blob_empty = shape_empty;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      error_count++;
      if (error_count <= 40)
         $display("mismatch on %s at cycle %0d: got %0d, expected %0d", what, cycle_count,
                  got, want);
   endtask

   // receiver: random stalls, or a counted hold-off when one is requested
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      blob_result_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (results_due.size() == 0) begin
            report_mismatch("result with nothing due", rsp_status, 0);
         end else begin
            want = results_due.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_run_total !== want.run_total)
               report_mismatch("run_total", rsp_run_total, want.run_total);
            if (rsp_pixel_total !== want.pixel_total)
               report_mismatch("pixel_total", rsp_pixel_total, want.pixel_total);
            if (rsp_top_row !== want.top_row)
               report_mismatch("top_row", rsp_top_row, want.top_row);
            if (rsp_bottom_row !== want.bottom_row)
               report_mismatch("bottom_row", rsp_bottom_row, want.bottom_row);
            if (rsp_blob_empty !== want.blob_empty)
               report_mismatch("blob_empty", rsp_blob_empty, want.blob_empty);
            if (rsp_read_left !== want.read_left)
               report_mismatch("read_left", rsp_read_left, want.read_left);
            if (rsp_read_right !== want.read_right)
               report_mismatch("read_right", rsp_read_right, want.read_right);
            if (rsp_read_y !== want.read_y)
               report_mismatch("read_y", rsp_read_y, want.read_y);
         end
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_item(input logic [OP_BITS-1:0] op, input coord_t xl, input coord_t xr,
                            input coord_t y, input logic [READ_ROW_BITS-1:0] rrow,
                            input logic [READ_SLOT_BITS-1:0] rslot);
      blob_req_t item;
      blob_result_t res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_x_left <= xl;
      req_x_right <= xr;
      req_row_y <= y;
      req_read_row <= rrow;
      req_read_slot <= rslot;
      item = '{op, xl, xr, y, rrow, rslot};
      do @(posedge clock); while (req_stall);
      res = next_blob_result(item);
      results_due.push_back(res);
      status_tally[res.status]++;
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_add(input coord_t xl, input coord_t xr, input coord_t y);
      send_item(OP_ADD, xl, xr, y, $urandom, $urandom);
   endtask

   task automatic send_read(input logic [READ_ROW_BITS-1:0] rrow,
                            input logic [READ_SLOT_BITS-1:0] rslot);
      send_item(OP_READ, $urandom, $urandom, $urandom, rrow, rslot);
   endtask

   task automatic send_clear();
      send_item(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic send_random_item(input shape_style_e style);
      int pick;
      int height;
      int inside_pct;
      int rr;
      coord_t xl;
      coord_t xr;
      coord_t y;
      logic [ROW_BITS-1:0] slot;
      pick = $urandom_range(99);
      height = shape_empty ? 0 : int'(last_row) - int'(first_row) + 1;
      if (pick < 4) begin
         send_item($urandom_range(3), $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 6) begin
         send_clear();
      end else if (pick < 26) begin
         if (height > 0 && $urandom_range(3) != 0) begin
            rr = $urandom_range(height > 63 ? 63 : height);
            slot = head_slot + rr[ROW_BITS-1:0];
            send_read(rr, $urandom_range(row_count[slot] > 15 ? 15 : row_count[slot]));
         end else begin
            send_read($urandom_range(63), $urandom_range(15));
         end
      end else begin
         pick = $urandom_range(99);
         if (pick < 6) begin
            xl = $urandom_range(1, COORD_MAX);
            xr = $urandom_range(0, int'(xl) - 1);
         end else if (pick < 14) begin
            xl = $urandom_range(1) ? '0 : '1;
            xr = ($urandom_range(1) || xl == '1) ? '1 : '0;
         end else if (pick < 30) begin
            xl = $urandom;
            xr = $urandom_range(int'(xl), COORD_MAX);
         end else begin
            xl = $urandom;
            rr = int'(xl) + $urandom_range(63);
            xr = rr > COORD_MAX ? COORD_MAX : rr;
         end
         case (style)
            GROW_TALL: inside_pct = 15;
            PACK_DENSE: inside_pct = 85;
            default: inside_pct = 50;
         endcase
         pick = $urandom_range(99);
         if (height == 0) begin
            if (pick < 20) y = '0;
            else if (pick < 40) y = '1;
            else y = $urandom;
         end else if (pick < inside_pct) begin
            y = first_row + $urandom_range(height - 1);
         end else if (pick < 96) begin
            y = $urandom_range(1) ? first_row - 1'b1 : last_row + 1'b1;
         end else begin
            y = $urandom;
         end
         send_add(xl, xr, y);
      end
   endtask

   task automatic test_empty_blob();
      send_read(0, 0);
      send_add('1, '0, 12'd50);
      send_item(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom);
      send_clear();
   endtask

   task automatic test_image_edges();
      send_add('0, '1, '0);
      send_add('1, '1, 12'd1);
      send_add(12'd5, 12'd9, '1);
      send_add('1, '0, 12'd1);
      send_read(0, 0);
      send_read(1, 0);
      send_read(2, 0);
      send_read(0, 1);
      send_clear();
      send_add('0, '0, '1);
      send_add('1, '1, '0);
      send_add(12'd7, 12'd7, 12'd4094);
      send_read('1, '1);
   endtask

   task automatic test_ordered_insert();
      send_clear();
      send_add(12'd100, 12'd200, 12'd2000);
      send_add(12'd10, 12'd20, 12'd2000);
      send_add(12'd300, 12'd400, 12'd2000);
      send_add(12'd150, 12'd160, 12'd2000);
      send_add('0, '1, 12'd2000);
      for (int s = 0; s < 5; s++) send_read(0, s);
   endtask

   task automatic test_full_row();
      coord_t y;
      coord_t xl;
      send_clear();
      y = $urandom;
      for (int i = 0; i < MAX_RUNS_PER_ROW + 2; i++) begin
         xl = $urandom;
         send_add(xl, $urandom_range(int'(xl), COORD_MAX), y);
      end
      for (int i = 0; i < 4; i++) send_read(0, $urandom_range(15));
   endtask

   task automatic test_full_height();
      coord_t xl;
      send_clear();
      xl = $urandom;
      send_add(xl, $urandom_range(int'(xl), COORD_MAX), $urandom_range(100, 3900));
      for (int i = 0; i < MAX_ROWS + 2; i++) begin
         xl = $urandom;
         send_add(xl, $urandom_range(int'(xl), COORD_MAX),
                  $urandom_range(1) ? first_row - 1'b1 : last_row + 1'b1);
      end
      for (int i = 0; i < 3; i++) send_read($urandom_range(63), 0);
   endtask

   task automatic test_random_blobs(input int n_items);
      int done;
      int len;
      shape_style_e style;
      done = 0;
      while (done < n_items) begin
         style = shape_style_e'($urandom_range(2));
         len = (style == GROW_TALL) ? 80 : $urandom_range(15, 40);
         if (len > n_items - done) len = n_items - done;
         send_clear();
         for (int i = 1; i < len; i++) send_random_item(style);
         done += len;
      end
   endtask

   task automatic test_backpressure();
      req_valid <= 1'b0;
      @(posedge clock);
      hold_cycles = 150;
      @(negedge clock);
      send_clear();
      for (int i = 0; i < 15; i++) send_random_item(PACK_DENSE);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_ADD;
      req_x_left = '0;
      req_x_right = '0;
      req_row_y = '0;
      req_read_row = '0;
      req_read_slot = '0;
      hold_cycles = 0;
      cycle_count = 0;
      error_count = 0;
      items_sent = 0;
      results_checked = 0;
      foreach (status_tally[s]) status_tally[s] = 0;
      send_idle_pct = 27;
      recv_idle_pct = 64;
      clear_shape();
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      test_empty_blob();
      test_image_edges();
      test_ordered_insert();
      test_full_row();
      test_random_blobs(90);

      send_idle_pct = 64;
      recv_idle_pct = 27;
      test_full_height();
      test_random_blobs(90);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      test_random_blobs(90);

      req_valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("covered %0d items and %0d results in %0d cycles, with a long receiver hold-off",
               items_sent, results_checked, cycle_count);
      $display("outcomes: ok %0d, not adjacent %0d, row full %0d, height full %0d, bad run %0d, bad read %0d",
               status_tally[ST_OK], status_tally[ST_NOT_ADJ], status_tally[ST_ROW_FULL],
               status_tally[ST_HEIGHT_FULL], status_tally[ST_BAD_RUN], status_tally[ST_BAD_READ]);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
